// ===== sv/sha256_pkg.sv =====
// SHA-256 shared package: round constants, initial hash values, item types.
// No dependencies; imported by every module of the stream hasher.
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } item_t;

    localparam int QDepth = 4;
    localparam int QAw    = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } eng_state_t;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
                6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
                6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
                6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
                6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        begin
            case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    localparam logic [7:0] PadByte = 8'h80;

endpackage
`default_nettype wire

// ===== sv/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher top level: front queue plus compression engine.
// Depends on sha256_pkg, sha256_front, sha256_engine.
//
// Takes one message byte per transaction and emits the 256-bit digest as
// eight 32-bit words after the item that carries end-of-message. Every
// 64th byte starts a compression (one round per cycle in the engine),
// during which input waits in a four-entry queue. Closing a message runs
// one or two final blocks, each a set-up state plus the rounds, then eight
// digest transactions.
`default_nettype none
module sha256_stream_hasher_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] msg_byte
    input  wire         s_tuser,   // [0] has_byte
    input  wire         s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [2:0]  m_tuser,   // [2:0] word_index
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.msg_byte       = s_tdata;
    assign in_item.has_byte       = s_tuser;
    assign in_item.end_of_message = s_tlast;

    sha256_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sha256_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_word(m_tdata), .out_index(m_tuser), .out_last(m_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/sha256_front.sv =====
// SHA-256 front end: accepts input transactions, drops idle items, queues the rest.
// Depends on sha256_pkg.
`default_nettype none
module sha256_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  sha256_pkg::item_t    in_item,
    output logic                 q_valid,
    input  wire                  q_ready,
    output sha256_pkg::item_t    q_item
);
    import sha256_pkg::*;

    item_t            mem [QDepth];
    logic [QAw-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAw:0]     count_reg;
    logic             push, pop, useful;

    assign useful   = in_item.has_byte | in_item.end_of_message;
    assign in_ready = (count_reg != QAw'(0) + (QAw+1)'(QDepth));
    // drop idle items at the door: they change nothing
    assign push     = in_valid & in_ready & useful;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid & q_ready;
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QAw+1)'(push) - (QAw+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == (QAw+1)'(QDepth) |-> !push || pop)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QAw+1)'(QDepth))
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/sha256_engine.sv =====
// SHA-256 back end: block packing, one-round-per-cycle compression, padding, digest out.
// Depends on sha256_pkg.
`default_nettype none
module sha256_engine (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  sha256_pkg::item_t    q_item,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [31:0]          out_word,
    output logic [2:0]           out_index,
    output logic                 out_last
);
    import sha256_pkg::*;

    eng_state_t    state_reg, state_next;
    logic [31:0]   w_reg [16];
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [5:0]    nbytes_reg;
    logic [63:0]   bitlen_reg;
    logic [5:0]    rnd_reg;
    logic          fin_reg;   // end of message pending: 0x80 not yet placed
    logic          len_blk_reg; // current compression is the length block
    logic          tail_reg;  // length did not fit: owe a block of its own
    logic [2:0]    oidx_reg;

    logic          take;
    logic          start_rnd;
    logic          rnd_done;
    logic [31:0]   wnew, t1, t2, s0, s1, bs1, bs0, ch, mj;

    // message schedule: w_reg is a 16-word sliding window
    assign s0  = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1  = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + s0 + w_reg[9] + s1;
    assign bs1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + bs1 + ch + round_k(rnd_reg) + w_reg[0];
    assign bs0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
    assign mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = bs0 + mj;
    assign rnd_done = (state_reg == ST_ROUND) && (rnd_reg == 6'd63);

    assign q_ready   = (state_reg == ST_IDLE);
    assign take      = q_valid & q_ready;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = h_reg[oidx_reg];
    assign out_index = oidx_reg;
    assign out_last  = (oidx_reg == 3'd7);

    // start a compression when the 64th byte lands or at padding points
    always_comb begin
        state_next = state_reg;
        start_rnd  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (q_item.has_byte && nbytes_reg == 6'd63) begin
                        state_next = ST_ROUND;
                        start_rnd  = 1'b1;
                    end else if (q_item.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (rnd_done) begin
                    if (len_blk_reg)      state_next = ST_EMIT;
                    else if (fin_reg)     state_next = ST_PAD;
                    else if (tail_reg)    state_next = ST_LEN;
                    else                  state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                state_next = ST_ROUND;
                start_rnd  = 1'b1;
            end
            ST_LEN: begin
                state_next = ST_ROUND;
                start_rnd  = 1'b1;
            end
            ST_EMIT: begin
                if (out_ready && out_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // block buffer, working variables and chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nbytes_reg  <= '0;
            bitlen_reg  <= '0;
            rnd_reg     <= '0;
            fin_reg     <= 1'b0;
            len_blk_reg <= 1'b0;
            tail_reg    <= 1'b0;
            oidx_reg    <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= init_h(3'(i));
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (q_item.has_byte) begin
                            w_reg[nbytes_reg[5:2]][8*(3-nbytes_reg[1:0]) +: 8]
                                <= q_item.msg_byte;
                            nbytes_reg <= nbytes_reg + 6'd1;
                            bitlen_reg <= bitlen_reg + 64'd8;
                        end
                        fin_reg     <= q_item.end_of_message;
                        len_blk_reg <= 1'b0;
                    end
                end
                ST_PAD: begin
                    // place 0x80 and clear the tail; add the length if it fits
                    for (int i = 0; i < 16; i++) begin
                        for (int b = 0; b < 4; b++) begin
                            if (!(nbytes_reg < 6'd56 && i >= 14)) begin
                                if (6'(4*i+b) == nbytes_reg)
                                    w_reg[i][8*(3-b) +: 8] <= PadByte;
                                else if (6'(4*i+b) > nbytes_reg)
                                    w_reg[i][8*(3-b) +: 8] <= 8'h00;
                            end
                        end
                    end
                    if (nbytes_reg < 6'd56) begin
                        w_reg[14]   <= bitlen_reg[63:32];
                        w_reg[15]   <= bitlen_reg[31:0];
                        len_blk_reg <= 1'b1;
                    end else begin
                        tail_reg    <= 1'b1;
                    end
                    fin_reg    <= 1'b0;
                    nbytes_reg <= '0;
                end
                ST_LEN: begin
                    // second padding block: zeros then length, no 0x80
                    for (int i = 0; i < 14; i++) w_reg[i] <= '0;
                    w_reg[14]   <= bitlen_reg[63:32];
                    w_reg[15]   <= bitlen_reg[31:0];
                    len_blk_reg <= 1'b1;
                    tail_reg    <= 1'b0;
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4]; v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0]; v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 6'd1;
                    if (rnd_done) begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[1] <= h_reg[1] + v_reg[0];
                        h_reg[2] <= h_reg[2] + v_reg[1];
                        h_reg[3] <= h_reg[3] + v_reg[2];
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        h_reg[5] <= h_reg[5] + v_reg[4];
                        h_reg[6] <= h_reg[6] + v_reg[5];
                        h_reg[7] <= h_reg[7] + v_reg[6];
                        nbytes_reg <= '0;
                    end
                end
                ST_EMIT: begin
                    if (out_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (out_last) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= init_h(3'(i));
                            bitlen_reg  <= '0;
                            nbytes_reg  <= '0;
                            len_blk_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (start_rnd) begin
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            end
        end
    end

    a_emit_from_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid) |-> $past(len_blk_reg))
        else $error("digest emitted without length block");
    a_idx_zero_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid) |-> oidx_reg == 3'd0)
        else $error("digest index not at zero");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> !q_ready)
        else $error("item taken mid-compression");

endmodule
`default_nettype wire
